// ===== design/pbri_pkg.sv =====
// ----------------------------------------------------------------------------
// pbri_pkg
// Shared constants and the prime base table for the radical inverse block.
// ----------------------------------------------------------------------------
package pbri_pkg;

  localparam int PRIME_COUNT = 64;
  localparam int DIM_BITS    = 6;
  localparam int DIMS_BITS   = 7;
  localparam int PRIME_BITS  = 9;
  localparam int INDEX_BITS  = 32;
  localparam int FRAC_BITS   = 32;
  localparam int COUNT_BITS  = 6;
  // p^n stays below 2^INDEX_BITS * max prime, so 41 bits cover it
  localparam int WIDE_BITS   = 41;

  localparam logic [DIMS_BITS-1:0] DIMS_RESET = 7'd64;

  // byte address of dimensions_in_use on the APB port
  localparam logic [2:0] DIMS_ADDR = 3'd0;

  localparam logic [PRIME_BITS-1:0] PRIMES [PRIME_COUNT] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

endpackage

// ===== design/prime_base_radical_inverse.sv =====
// ----------------------------------------------------------------------------
// prime_base_radical_inverse
// Radical inverse of a sample index in a prime base (Halton component).
// ----------------------------------------------------------------------------
// Input stream: one item holds a dimension and a sample index. The dimension
// picks prime p from a fixed table of the first 64 primes. The result item
// holds floor(R * 2^32 / p^n), where R is the base-p digit reversal of the
// index and n its digit count, plus n and a bad-dimension flag in tuser.
// A dimension not below dimensions_in_use (APB register at address 0) gives
// a zero fraction, zero count and the flag set.
// Steps: each digit passes a reciprocal multiply state, then a remainder
// correction and accumulate state (n <= 32 digits); then the bit-serial
// scaling divider runs until its done flag, and the output register is
// loaded once it is free. The next item is taken only after that load.
// A zero index or a bad dimension skips the digit and divider steps and goes
// straight to the output register load. s_tready is high only while the
// sequencer is idle, one item in work at a time.
// The result sits in an output register until taken; a stalled receiver holds
// the finished item, the block still takes and works on the next one, which
// then waits in the sequencer, input blocked, until the output register frees.
// Reset (rst, synchronous) empties the block and sets dimensions_in_use to 64.
// ----------------------------------------------------------------------------
module prime_base_radical_inverse (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // dimension[5:0], sample_index[37:6], zero pad
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // fraction[31:0], digit_count[37:32], zero pad
  output logic [0:0]  m_tuser    // bad_dimension[0]
);

  localparam int PB = pbri_pkg::PRIME_BITS;
  localparam int IB = pbri_pkg::INDEX_BITS;
  localparam int WB = pbri_pkg::WIDE_BITS;
  localparam int FB = pbri_pkg::FRAC_BITS;
  localparam int CB = pbri_pkg::COUNT_BITS;
  localparam int DB = pbri_pkg::DIM_BITS;
  localparam logic REG_DIMS = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIGIT,
    S_DIV,
    S_OUT
  } state_t;

  // floor(2^32 / p) per table entry; the quotient estimate is then short by
  // at most one
  logic [IB-1:0] recip_tab [pbri_pkg::PRIME_COUNT];
  for (genvar g = 0; g < pbri_pkg::PRIME_COUNT; g++) begin : g_recip
    localparam logic [IB:0] RECIP = (IB+1)'((65'd1 << IB) / pbri_pkg::PRIMES[g]);
    assign recip_tab[g] = RECIP[IB-1:0];
  end

  state_t                        state;
  logic [pbri_pkg::DIMS_BITS-1:0] dims;
  logic [DB-1:0]                 in_dim;
  logic [IB-1:0]                 in_index;
  logic                          in_bad;
  logic [PB-1:0]                 prime;
  logic [IB-1:0]                 recip;
  logic [IB-1:0]                 work;
  logic [IB-1:0]                 prod_hi;
  logic [WB-1:0]                 reversed;
  logic [WB-1:0]                 power;
  logic [CB-1:0]                 count;
  logic [FB-1:0]                 frac;
  logic                          bad;

  logic [WB-1:0]                 qp;
  logic [IB-1:0]                 rem_est;
  logic                          corr;
  logic [PB-1:0]                 digit;
  logic [IB-1:0]                 work_next;
  logic [WB-1:0]                 reversed_next;
  logic [WB-1:0]                 power_next;
  logic                          div_start;
  logic                          div_done;
  logic [FB-1:0]                 div_quo;

  assign in_dim   = s_tdata[DB-1:0];
  assign in_index = s_tdata[DB+IB-1:DB];
  assign in_bad   = {1'b0, in_dim} >= dims;
  assign s_tready = (state == S_IDLE);

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIMS) ? {25'd0, dims} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= pbri_pkg::DIMS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DIMS) begin
      dims <= pwdata[pbri_pkg::DIMS_BITS-1:0];
    end
  end

  // digit step: fix the quotient estimate, peel one digit, accumulate
  always_comb begin
    qp            = WB'(prod_hi) * WB'(prime);
    rem_est       = work - qp[IB-1:0];
    corr          = rem_est >= IB'(prime);
    digit         = corr ? rem_est[PB-1:0] - prime : rem_est[PB-1:0];
    work_next     = prod_hi + IB'(corr);
    reversed_next = reversed * WB'(prime) + WB'(digit);
    power_next    = power * WB'(prime);
  end

  assign div_start = (state == S_DIGIT) && (work_next == '0);

  pbri_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (reversed_next),
    .den   (power_next),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // in S_OUT a taken result is replaced below
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            work     <= in_index;
            prime    <= pbri_pkg::PRIMES[in_dim];
            recip    <= recip_tab[in_dim];
            reversed <= '0;
            power    <= WB'(1);
            count    <= '0;
            frac     <= '0;
            bad      <= in_bad;
            state    <= (in_bad || in_index == '0) ? S_OUT : S_MUL;
          end
        end
        S_MUL: begin
          prod_hi <= IB'((2*IB)'(work) * (2*IB)'(recip) >> IB);
          state   <= S_DIGIT;
        end
        S_DIGIT: begin
          work     <= work_next;
          reversed <= reversed_next;
          power    <= power_next;
          count    <= count + 1'b1;
          state    <= (work_next == '0) ? S_DIV : S_MUL;
        end
        S_DIV: begin
          if (div_done) begin
            frac  <= div_quo;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {2'b00, count, frac};
            m_tuser  <= bad;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/pbri_frac_div.sv =====
// ----------------------------------------------------------------------------
// pbri_frac_div
// Restoring divider: floor(num * 2^FRAC_BITS / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pbri_frac_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pbri_pkg::WIDE_BITS-1:0] num,
  input  logic [pbri_pkg::WIDE_BITS-1:0] den,
  output logic                           done,
  output logic [pbri_pkg::FRAC_BITS-1:0] quo
);

  localparam int CNT_BITS = $clog2(pbri_pkg::FRAC_BITS);

  logic                           busy;
  logic [CNT_BITS-1:0]            cnt;
  logic [pbri_pkg::WIDE_BITS:0]   rem;
  logic [pbri_pkg::WIDE_BITS-1:0] divisor;
  logic [pbri_pkg::WIDE_BITS:0]   shifted;
  logic                           fits;

  // num < den always holds, so the shifted remainder fits in one extra bit
  assign shifted = {rem[pbri_pkg::WIDE_BITS-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= {1'b0, num};
      divisor <= den;
      quo     <= '0;
      cnt     <= CNT_BITS'(pbri_pkg::FRAC_BITS - 1);
    end else if (busy) begin
      rem <= fits ? shifted - {1'b0, divisor} : shifted;
      quo <= {quo[pbri_pkg::FRAC_BITS-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== test/pbri_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pbri_checker
// Watches the APB port and both item streams of the radical inverse block,
// keeps its own copy of the dimension limit and the prime bases, predicts each
// result item when its input item is taken and compares it field by field
// with the result items as they leave. Register reads are checked as well.
// ----------------------------------------------------------------------------
module pbri_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // dimension[5:0], sample_index[37:6], zero pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // fraction[31:0], digit_count[37:32], zero pad
  input  logic [0:0]  m_tuser,   // bad_dimension[0]
  output int unsigned pending,
  output int unsigned failures
);

  typedef struct packed {
    logic [pbri_pkg::FRAC_BITS-1:0]  fraction;
    logic [pbri_pkg::COUNT_BITS-1:0] digits;
    logic                            bad;
  } inverse_t;

  inverse_t                       inverse_q[$];
  logic [pbri_pkg::DIMS_BITS-1:0] dims_in_use;
  longint unsigned                base_of[pbri_pkg::PRIME_COUNT];

  initial begin : fill_bases
    int unsigned     found;
    longint unsigned cand;
    bit              is_prime;
    found = 0;
    cand  = 2;
    while (found < pbri_pkg::PRIME_COUNT) begin
      is_prime = 1'b1;
      for (int k = 0; k < found; k++)
        if (cand % base_of[k] == 0) is_prime = 1'b0;
      if (is_prime) begin
        base_of[found] = cand;
        found++;
      end
      cand++;
    end
  end

  // digit reversal behind the radix point, then floor(R * 2^32 / p^n)
  function automatic inverse_t radical_inverse(
    input logic [pbri_pkg::DIM_BITS-1:0]   dim,
    input logic [pbri_pkg::INDEX_BITS-1:0] idx);
    inverse_t        r;
    longint unsigned base, work, rev, pw, rem, quo;
    int unsigned     n;
    r = '0;
    if (dim >= dims_in_use || dim >= pbri_pkg::PRIME_COUNT) begin
      r.bad = 1'b1;
      return r;
    end
    base = base_of[dim];
    work = 64'(idx);
    rev  = 0;
    pw   = 1;
    n    = 0;
    while (work != 0) begin
      rev  = rev * base + work % base;
      pw   = pw * base;
      work = work / base;
      n++;
    end
    rem = rev;
    quo = 0;
    for (int i = 0; i < pbri_pkg::FRAC_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= pw) begin
        rem = rem - pw;
        quo = quo | 1;
      end
    end
    r.fraction = quo[pbri_pkg::FRAC_BITS-1:0];
    r.digits   = n[pbri_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    inverse_t    want, got;
    int unsigned errs;
    errs = 0;
    if (rst) begin
      dims_in_use <= pbri_pkg::DIMS_RESET;
      inverse_q.delete();
      pending  <= 0;
      failures <= 0;
    end else begin
      if (psel && penable && pready && paddr == pbri_pkg::DIMS_ADDR) begin
        if (pwrite)
          dims_in_use <= pwdata[pbri_pkg::DIMS_BITS-1:0];
        else if (prdata !== 32'(dims_in_use)) begin
          $display("%0t: dimensions_in_use read: expected %h, got %h",
                   $time, 32'(dims_in_use), prdata);
          errs++;
        end
      end
      if (m_tvalid && m_tready) begin
        got.fraction = m_tdata[31:0];
        got.digits   = m_tdata[37:32];
        got.bad      = m_tuser[0];
        if (inverse_q.size() == 0) begin
          $display("%0t: result item with nothing expected: expected none, got %h",
                   $time, got);
          errs++;
        end else begin
          want = inverse_q.pop_front();
          if (got.fraction !== want.fraction) begin
            $display("%0t: fraction: expected %h, got %h", $time,
                     want.fraction, got.fraction);
            errs++;
          end
          if (got.digits !== want.digits) begin
            $display("%0t: digit_count: expected %0d, got %0d", $time,
                     want.digits, got.digits);
            errs++;
          end
          if (got.bad !== want.bad) begin
            $display("%0t: bad_dimension: expected %b, got %b", $time,
                     want.bad, got.bad);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready)
        inverse_q.push_back(radical_inverse(s_tdata[5:0], s_tdata[37:6]));
      pending <= inverse_q.size();
      if (errs != 0) failures <= failures + errs;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the prime base radical inverse block: directed corner items
// under several dimension limits, then random phases with random idle gaps on
// both streams, one long output stall and one phase with no gaps at all.
// Checking is done by pbri_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int         HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_tvalid, s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;

  int unsigned pending, failures;
  int unsigned dims_now;
  bit          steady;
  bit          hold_req;

  prime_base_radical_inverse uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  pbri_checker chk (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pending  (pending),
    .failures (failures)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  task automatic apb_access(input bit wr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= pbri_pkg::DIMS_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // only while idle: all results back, then a short margin
  task automatic set_dims(input int unsigned v);
    s_tvalid <= 1'b0;
    // let the count of the last taken item settle first
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    apb_access(1'b1, ($urandom & ~32'h7F) | v);
    apb_access(1'b0, 32'h0);
    dims_now = v;
  endtask

  task automatic send_item(input logic [5:0] dim, input logic [31:0] idx);
    int unsigned g;
    g = steady ? 0 : idle_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, idx, dim};
    do @(posedge clk); while (!s_tready);
  endtask

  // receiver
  initial begin
    int unsigned g;
    bit          held;
    held = 1'b0;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        g = idle_gap();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [5:0]      dim;
    logic [31:0]     idx;
    longint unsigned pw, p;
    int unsigned     pick, k, lim;
    int unsigned     plan_dims[6];
    int unsigned     plan_items[6];

    steady   = 1'b0;
    hold_req = 1'b0;
    dims_now = 32'(pbri_pkg::DIMS_RESET);
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset limit of 64: every dimension valid
    apb_access(1'b0, 32'h0);
    send_item(6'd0,  32'd0);
    send_item(6'd0,  32'd1);
    send_item(6'd0,  32'hFFFF_FFFF);
    send_item(6'd0,  32'h8000_0000);
    send_item(6'd63, 32'd0);
    send_item(6'd63, 32'hFFFF_FFFF);
    send_item(6'd63, 32'd310);
    send_item(6'd63, 32'd311);
    send_item(6'd63, 32'd96721);          // 311^2
    send_item(6'd1,  32'd3486784401);     // 3^20
    send_item(6'd1,  32'd3486784400);
    send_item(6'd2,  32'd1220703125);     // 5^13
    send_item(6'd31, 32'h5A5A_5A5A);
    send_item(6'd17, 32'hA5A5_A5A5);
    // narrowest nonzero limit
    set_dims(1);
    send_item(6'd0,  32'd12345);
    send_item(6'd1,  32'd12345);
    send_item(6'd63, 32'd0);
    // zero limit rejects everything
    set_dims(0);
    send_item(6'd0,  32'd7);
    send_item(6'd0,  32'd0);
    // oversized limit, bounded by the table size
    set_dims(127);
    send_item(6'd63, 32'hFFFF_FFFF);
    send_item(6'd62, 32'd1);

    plan_dims  = '{64, 0, 1, 127, 0, 64};
    plan_items = '{300, 250, 120, 200, 40, 100};
    plan_dims[1] = $urandom_range(2, 63);

    for (int ph = 0; ph < 6; ph++) begin
      set_dims(plan_dims[ph]);
      steady = (ph == 3);
      for (int n = 0; n < plan_items[ph]; n++) begin
        if (ph == 0 && n == 100) hold_req = 1'b1;
        lim = (dims_now > pbri_pkg::PRIME_COUNT) ? pbri_pkg::PRIME_COUNT : dims_now;
        if (lim > 0 && $urandom_range(0, 4) != 0)
          dim = 6'($urandom_range(0, lim - 1));
        else
          dim = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 9);
        if (pick < 3)
          idx = $urandom;
        else if (pick < 5)
          idx = $urandom_range(0, 1000);
        else if (pick < 7) begin
          // around a power of the base: digit count steps here
          p  = 64'(pbri_pkg::PRIMES[dim]);
          pw = 1;
          k  = $urandom_range(1, 32);
          while (k > 0 && pw * p <= 64'hFFFF_FFFF) begin
            pw = pw * p;
            k--;
          end
          idx = 32'(pw + $urandom_range(0, 2) - 1);
        end else if (pick < 8)
          idx = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        else
          idx = $urandom >> $urandom_range(0, 31);
        send_item(dim, idx);
      end
      steady = 1'b0;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (150) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
